// ===== src/pbdma_pkg.sv =====
package pbdma_pkg;

  localparam int MAX_REPLY_WORDS = 128;
  localparam int MAX_COMMANDS = 65535;
  localparam int RC_W = $clog2(MAX_REPLY_WORDS + 1);
  localparam int QDEPTH = 4;
  localparam int QA_W = $clog2(QDEPTH);

  localparam logic [15:0] PROT_KEY = 16'h6155;
  localparam logic [31:0] PROT_MASK = 32'h00007F7F;
  localparam logic [31:0] LIST_MASK = 32'h1FFFFFE0;
  localparam logic [31:0] SYSCTL_MASK = 32'hFFFF130F;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  localparam logic [7:0] OFF_LIST = 8'h04;
  localparam logic [7:0] OFF_TRIG = 8'h10;
  localparam logic [7:0] OFF_GEN = 8'h14;
  localparam logic [7:0] OFF_START = 8'h18;
  localparam logic [7:0] OFF_SYSCTL = 8'h80;
  localparam logic [7:0] OFF_RPTCLR = 8'h88;
  localparam logic [7:0] OFF_PROT = 8'h8C;
  localparam logic [7:0] OFF_MODE = 8'hE8;

  typedef enum logic [1:0] {
    F_READ = 2'd0,
    F_WRITE = 2'd1,
    F_MEM = 2'd2,
    F_PORT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_READ = 3'd0,
    K_BAD = 3'd1,
    K_MREQ = 3'd2,
    K_PWRITE = 3'd3,
    K_PREQ = 3'd4,
    K_MWRITE = 3'd5,
    K_DONE = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD = 3'd1,
    PH_RXPTR = 3'd2,
    PH_DATA = 3'd3,
    PH_REPLY = 3'd4
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] address;
    logic [31:0] data;
    logic [1:0] port;
  } result_t;

  typedef struct packed {
    logic two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic push;
    entry_t entry;
  } push_t;

  function automatic result_t mk(kind_t k, logic [31:0] a, logic [31:0] d, logic [1:0] p);
    result_t r;
    r.kind = k;
    r.address = a;
    r.data = d;
    r.port = p;
    return r;
  endfunction

endpackage

// ===== src/peripheral_bus_dma_controller.sv =====
// Register window and descriptor-list DMA engine for a four-port peripheral bus.
// s_axis carries one request or returned word per word: tuser is the function
// (register read, register write, memory word, port word). m_axis carries the
// results: register read data or a bad-register flag, memory read and write
// requests, port writes and port read requests, and the done interrupt.
// A request produces zero, one or two result words; tlast marks the final one.
// Requests are decoded and executed on acceptance, and their results are
// registered into a four-entry queue and leave one word per cycle while the
// receiver is ready. One request is taken every cycle while the queue has
// room; a request with two results leaves as two words from one queue entry.
// If the receiver stalls, results wait in the queue and s_tready drops only
// when the queue is full or reset is held. Synchronous reset clears all
// registers but the queue storage, the engine returns to idle and the queue is emptied.
module peripheral_bus_dma_controller
  import pbdma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // reg_offset, write_value, return_word, port_more
  input  logic [1:0]  s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // address, data, port
  output logic [2:0]  m_tuser,  // kind
  output logic        m_tlast
);

  push_t push;
  logic full, empty, pop;
  entry_t head;
  result_t res;
  logic fire;

  assign s_tready = !full && !rst;
  assign fire = s_tvalid && s_tready;

  pbdma_front u_front (
    .clk, .rst, .fire,
    .func(s_tuser),
    .reg_offset(s_tdata[7:0]),
    .write_value(s_tdata[39:8]),
    .return_word(s_tdata[71:40]),
    .port_more(s_tdata[72]),
    .push
  );

  pbdma_queue u_queue (.clk, .rst, .push, .pop, .full, .empty, .head);

  pbdma_back u_back (
    .clk, .rst, .empty, .head, .pop,
    .valid(m_tvalid), .ready(m_tready), .res, .last(m_tlast)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {6'd0, res.port, res.data, res.address};

endmodule

// ===== src/pbdma_front.sv =====
module pbdma_front
  import pbdma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [1:0]  func,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_value,
  input  logic [31:0] return_word,
  input  logic        port_more,
  output push_t       push
);

  logic [28:0] list_start, list_start_next;
  logic trig, trig_next, gen, gen_next, start, start_next, mode, mode_next;
  logic lock, lock_next, end_m, end_m_next;
  logic [31:0] sysctl, sysctl_next, fa, fa_next, ra, ra_next;
  logic [14:0] prot, prot_next;
  phase_t phase, phase_next;
  logic [8:0] sr, sr_next, srd;
  logic [RC_W-1:0] rc, rc_next, rcn;
  logic [1:0] cport, cport_next;
  logic [15:0] cc, cc_next, ccn;
  logic [31:0] rv;
  logic rv_ok;
  result_t r0, r1;
  logic n1, n2;

  always_comb begin
    rv_ok = 1'b1;
    case (reg_offset)
      OFF_LIST: rv = {3'd0, list_start};
      OFF_TRIG: rv = {31'd0, trig};
      OFF_GEN: rv = {31'd0, gen};
      OFF_START: rv = {31'd0, start};
      OFF_SYSCTL: rv = sysctl;
      OFF_PROT: rv = {17'd0, prot};
      OFF_MODE: rv = {31'd0, mode};
      default: begin
        rv = '0;
        rv_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    list_start_next = list_start;
    trig_next = trig;
    gen_next = gen;
    start_next = start;
    mode_next = mode;
    lock_next = lock;
    end_m_next = end_m;
    sysctl_next = sysctl;
    prot_next = prot;
    fa_next = fa;
    ra_next = ra;
    phase_next = phase;
    sr_next = sr;
    rc_next = rc;
    cport_next = cport;
    cc_next = cc;
    r0 = '0;
    r1 = '0;
    n1 = 1'b0;
    n2 = 1'b0;
    srd = sr - 9'(sr != 9'd0);
    rcn = rc + RC_W'(1);
    ccn = cc + 16'd1;
    case (func_t'(func))
      F_READ: begin
        n1 = 1'b1;
        r0 = rv_ok ? mk(K_READ, '0, rv, '0) : mk(K_BAD, '0, '0, '0);
      end
      F_WRITE: begin
        case (reg_offset)
          OFF_LIST: list_start_next = 29'(write_value & LIST_MASK);
          OFF_TRIG: trig_next = write_value[0];
          OFF_GEN: gen_next = write_value[0];
          OFF_START: begin
            if (phase == PH_IDLE) begin
              start_next = write_value[0];
              if (write_value[0] && gen && !(lock && trig)) begin
                if (trig) lock_next = 1'b1;
                n1 = 1'b1;
                r0 = mk(K_MREQ, {3'd0, list_start}, '0, '0);
                fa_next = {3'd0, list_start} + 32'd4;
                cc_next = '0;
                end_m_next = 1'b0;
                phase_next = PH_CMD;
              end
            end
          end
          OFF_SYSCTL: sysctl_next = write_value & SYSCTL_MASK;
          OFF_RPTCLR: if (write_value[0]) lock_next = 1'b0;
          OFF_PROT: if (write_value[31:16] == PROT_KEY) prot_next = 15'(write_value & PROT_MASK);
          OFF_MODE: mode_next = write_value[0];
          default: begin
            n1 = 1'b1;
            r0 = mk(K_BAD, '0, '0, '0);
          end
        endcase
      end
      F_MEM: begin
        case (phase)
          PH_CMD: begin
            sr_next = {1'b0, return_word[7:0]} + 9'd1;
            cport_next = return_word[17:16];
            end_m_next = return_word[31];
            phase_next = PH_RXPTR;
            n1 = 1'b1;
            r0 = mk(K_MREQ, fa, '0, '0);
            fa_next = fa + 32'd4;
          end
          PH_RXPTR: begin
            ra_next = return_word;
            phase_next = PH_DATA;
            n1 = 1'b1;
            r0 = mk(K_MREQ, fa, '0, '0);
            fa_next = fa + 32'd4;
          end
          PH_DATA: begin
            n2 = 1'b1;
            r0 = mk(K_PWRITE, '0, return_word, cport);
            sr_next = srd;
            if (srd != 9'd0) begin
              r1 = mk(K_MREQ, fa, '0, '0);
              fa_next = fa + 32'd4;
            end else begin
              rc_next = '0;
              phase_next = PH_REPLY;
              r1 = mk(K_PREQ, '0, '0, cport);
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase == PH_REPLY) begin
          n2 = 1'b1;
          r0 = mk(K_MWRITE, ra, return_word, cport);
          ra_next = ra + 32'd4;
          rc_next = rcn;
          if ((rcn == RC_W'(1) && return_word == ALL_ONES) || !port_more ||
              rcn >= RC_W'(MAX_REPLY_WORDS)) begin
            cc_next = ccn;
            if (end_m || ccn >= 16'(MAX_COMMANDS)) begin
              start_next = 1'b0;
              phase_next = PH_IDLE;
              r1 = mk(K_DONE, '0, '0, '0);
            end else begin
              phase_next = PH_CMD;
              r1 = mk(K_MREQ, fa, '0, '0);
              fa_next = fa + 32'd4;
            end
          end else begin
            r1 = mk(K_PREQ, '0, '0, cport);
          end
        end
      end
    endcase
  end

  always_comb begin
    push.push = fire && (n1 || n2);
    push.entry.two = n2;
    push.entry.r0 = r0;
    push.entry.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_start <= '0;
      trig <= 1'b0;
      gen <= 1'b0;
      start <= 1'b0;
      mode <= 1'b0;
      lock <= 1'b0;
      end_m <= 1'b0;
      sysctl <= '0;
      prot <= '0;
      fa <= '0;
      ra <= '0;
      phase <= PH_IDLE;
      sr <= '0;
      rc <= '0;
      cport <= '0;
      cc <= '0;
    end else if (fire) begin
      list_start <= list_start_next;
      trig <= trig_next;
      gen <= gen_next;
      start <= start_next;
      mode <= mode_next;
      lock <= lock_next;
      end_m <= end_m_next;
      sysctl <= sysctl_next;
      prot <= prot_next;
      fa <= fa_next;
      ra <= ra_next;
      phase <= phase_next;
      sr <= sr_next;
      rc <= rc_next;
      cport <= cport_next;
      cc <= cc_next;
    end
  end

endmodule

// ===== src/pbdma_queue.sv =====
module pbdma_queue
  import pbdma_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t mem [QDEPTH];
  logic [QA_W-1:0] wp, rp;
  logic [QA_W:0] cnt;

  assign full = cnt == (QA_W+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push.push) mem[wp] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push.push) wp <= wp + QA_W'(1);
      if (pop) rp <= rp + QA_W'(1);
      cnt <= cnt + (QA_W+1)'(push.push) - (QA_W+1)'(pop);
    end
  end

endmodule

// ===== src/pbdma_back.sv =====
module pbdma_back
  import pbdma_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   empty,
  input  entry_t head,
  output logic   pop,
  output logic   valid,
  input  logic   ready,
  output result_t res,
  output logic   last
);

  logic sel;

  assign valid = !empty;
  assign res = sel ? head.r1 : head.r0;
  assign last = sel || !head.two;
  assign pop = valid && ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (valid && ready) begin
      sel <= !last;
    end
  end

endmodule

// ===== src/pbdma_checker.sv =====
module pbdma_checker
  import pbdma_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output dropped while stalled");
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == K_READ || m_tuser == K_BAD || m_tuser == K_DONE) |-> m_tlast)
    else $error("single result not last");
  a_pwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == K_PWRITE |-> !m_tlast)
    else $error("port write marked last");

endmodule

bind peripheral_bus_dma_controller pbdma_checker u_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tuser, .m_tlast
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pbdma_pkg::*;

  typedef struct {
    kind_t kind;
    logic [31:0] address;
    logic [31:0] data;
    logic [1:0] port;
    logic last;
  } word_t;

  class dma_scoreboard;
    logic [31:0] list_start, trig, gen, start_st, sysctl, prot, mode, rlock;
    phase_t phase;
    logic [31:0] fetch_addr, rx_addr;
    int send_left, rx_count;
    logic [1:0] cur_port;
    logic end_mark;
    int cmd_count;
    word_t pending[$];
    word_t step_out[$];
    int errors;

    function new();
      list_start = 0; trig = 0; gen = 0; start_st = 0; sysctl = 0; prot = 0;
      mode = 0; rlock = 0; phase = PH_IDLE; fetch_addr = 0; rx_addr = 0;
      send_left = 0; rx_count = 0; cur_port = 0; end_mark = 0; cmd_count = 0;
      errors = 0;
    endfunction

    function void put(kind_t k, logic [31:0] a, logic [31:0] d, logic [1:0] p);
      word_t w;
      w.kind = k; w.address = a; w.data = d; w.port = p; w.last = 0;
      step_out.push_back(w);
    endfunction

    function void fetch();
      put(K_MREQ, fetch_addr, 0, 0);
      fetch_addr += 4;
    endfunction

    function void end_command();
      cmd_count = (cmd_count + 1) & 16'hFFFF;
      if (end_mark || cmd_count >= MAX_COMMANDS) begin
        start_st = 0;
        phase = PH_IDLE;
        put(K_DONE, 0, 0, 0);
      end else begin
        phase = PH_CMD;
        fetch();
      end
    endfunction

    function void note_request(func_t f, logic [7:0] off, logic [31:0] val,
                               logic [31:0] rw, logic more);
      logic [31:0] v;
      logic ok;
      step_out.delete();
      case (f)
        F_READ: begin
          ok = 1;
          case (off)
            OFF_LIST: v = list_start;
            OFF_TRIG: v = trig;
            OFF_GEN: v = gen;
            OFF_START: v = start_st;
            OFF_SYSCTL: v = sysctl;
            OFF_PROT: v = prot;
            OFF_MODE: v = mode;
            default: ok = 0;
          endcase
          if (ok) put(K_READ, 0, v, 0);
          else put(K_BAD, 0, 0, 0);
        end
        F_WRITE: begin
          case (off)
            OFF_LIST: list_start = val & LIST_MASK;
            OFF_TRIG: trig = val & 1;
            OFF_GEN: gen = val & 1;
            OFF_START: begin
              if (phase == PH_IDLE) begin
                start_st = val & 1;
                if (val[0] && gen[0] && !(rlock[0] && trig[0])) begin
                  if (trig[0]) rlock = 1;
                  fetch_addr = list_start;
                  cmd_count = 0;
                  end_mark = 0;
                  phase = PH_CMD;
                  fetch();
                end
              end
            end
            OFF_SYSCTL: sysctl = val & SYSCTL_MASK;
            OFF_RPTCLR: if (val[0]) rlock = 0;
            OFF_PROT: if (val[31:16] == PROT_KEY) prot = val & PROT_MASK;
            OFF_MODE: mode = val & 1;
            default: put(K_BAD, 0, 0, 0);
          endcase
        end
        F_MEM: begin
          case (phase)
            PH_CMD: begin
              send_left = rw[7:0] + 1;
              cur_port = rw[17:16];
              end_mark = rw[31];
              phase = PH_RXPTR;
              fetch();
            end
            PH_RXPTR: begin
              rx_addr = rw;
              phase = PH_DATA;
              fetch();
            end
            PH_DATA: begin
              put(K_PWRITE, 0, rw, cur_port);
              if (send_left > 0) send_left--;
              if (send_left > 0) fetch();
              else begin
                rx_count = 0;
                phase = PH_REPLY;
                put(K_PREQ, 0, 0, cur_port);
              end
            end
            default: ;
          endcase
        end
        default: begin
          if (phase == PH_REPLY) begin
            put(K_MWRITE, rx_addr, rw, cur_port);
            rx_addr += 4;
            rx_count++;
            if ((rx_count == 1 && rw == ALL_ONES) || !more ||
                rx_count >= MAX_REPLY_WORDS) end_command();
            else put(K_PREQ, 0, 0, cur_port);
          end
        end
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
      foreach (step_out[i]) pending.push_back(step_out[i]);
    endfunction

    function void check_result(word_t got);
      word_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: kind %0d", got.kind);
        return;
      end
      exp = pending.pop_front();
      if (got.kind != exp.kind || got.address !== exp.address ||
          got.data !== exp.data || got.port !== exp.port || got.last !== exp.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp k%0d a%h d%h p%0d l%0d, got k%0d a%h d%h p%0d l%0d",
                   exp.kind, exp.address, exp.data, exp.port, exp.last,
                   got.kind, got.address, got.data, got.port, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [79:0] s_tdata = 0;
  logic [1:0] s_tuser = 0;
  logic m_tvalid, m_tready = 0;
  logic [71:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  dma_scoreboard sb;
  int cycles = 0;
  int n_sent = 0;
  logic sink_on = 0;

  peripheral_bus_dma_controller i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, check on rising edge
  always @(posedge clk) begin
    word_t w;
    if (!rst && m_tvalid && m_tready) begin
      w.kind = kind_t'(m_tuser);
      w.address = m_tdata[31:0];
      w.data = m_tdata[63:32];
      w.port = m_tdata[65:64];
      w.last = m_tlast;
      sb.check_result(w);
    end
  end

  initial begin
    int g;
    wait (sink_on);
    forever begin
      @(negedge clk);
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(negedge clk);
      end
      m_tready <= 1;
    end
  end

  task automatic send(func_t f, logic [7:0] off, logic [31:0] val,
                      logic [31:0] rw, logic more);
    int g;
    g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= f;
    s_tdata <= {7'b0, more, rw, val, off};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(f, off, val, rw, more);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return ALL_ONES;
      default: return $urandom();
    endcase
  endfunction

  // one whole command list with random content and occasional noise
  task automatic run_list(int ncmd, logic trig_on);
    logic [31:0] cw;
    int n, k;
    logic more;
    send(F_WRITE, OFF_LIST, rnd32(), 0, 0);
    send(F_WRITE, OFF_TRIG, {31'($urandom()), trig_on}, 0, 0);
    send(F_WRITE, OFF_GEN, 32'h1, 0, 0);
    send(F_WRITE, OFF_RPTCLR, 32'h1, 0, 0);
    send(F_WRITE, OFF_START, {31'($urandom()), 1'b1}, 0, 0);
    for (int c = 0; c < ncmd; c++) begin
      cw = $urandom();
      cw[7:0] = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
      cw[31] = (c == ncmd - 1);
      send(F_MEM, 8'($urandom()), $urandom(), cw, 1'($urandom()));
      send(F_MEM, 8'($urandom()), $urandom(), rnd32(), 1'($urandom()));
      if ($urandom_range(0, 5) == 0) send(F_PORT, 0, 0, $urandom(), 1);
      if ($urandom_range(0, 5) == 0) send(F_READ, OFF_START, 0, 0, 0);
      if ($urandom_range(0, 7) == 0) send(F_WRITE, OFF_START, 1, 0, 0);
      for (int i = 0; i <= cw[7:0]; i++) send(F_MEM, 0, 0, rnd32(), 0);
      n = ($urandom_range(0, 20) == 0) ? 130 : $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        more = (k != n - 1);
        send(F_PORT, 8'($urandom()), $urandom(),
             (k == 0 && $urandom_range(0, 9) == 0) ? ALL_ONES : $urandom(), more);
        if (sb.phase != PH_REPLY) break;
      end
      if (sb.phase == PH_IDLE) break;
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    sink_on = 1;

    send(F_READ, OFF_LIST, 0, 0, 0);
    send(F_READ, 8'h00, 0, 0, 0);
    send(F_READ, OFF_RPTCLR, 0, 0, 0);
    send(F_WRITE, 8'hFF, ALL_ONES, 0, 0);
    send(F_WRITE, OFF_LIST, ALL_ONES, 0, 0);
    send(F_WRITE, OFF_SYSCTL, ALL_ONES, 0, 0);
    send(F_WRITE, OFF_PROT, ALL_ONES, 0, 0);
    send(F_WRITE, OFF_PROT, {PROT_KEY, 16'hFFFF}, 0, 0);
    send(F_WRITE, OFF_MODE, ALL_ONES, 0, 0);
    send(F_WRITE, OFF_START, 32'h1, 0, 0);
    send(F_MEM, 0, 0, ALL_ONES, 1);
    send(F_PORT, 0, 0, ALL_ONES, 1);
    send(F_READ, OFF_START, 0, 0, 0);
    send(F_READ, OFF_SYSCTL, 0, 0, 0);
    send(F_READ, OFF_PROT, 0, 0, 0);
    send(F_READ, OFF_MODE, 0, 0, 0);
    settle();
    run_list(2, 1);
    send(F_WRITE, OFF_START, 32'h1, 0, 0);
    send(F_READ, OFF_START, 0, 0, 0);
    settle();

    while (n_sent < 400) begin
      if ($urandom_range(0, 3) == 0) begin
        send(func_t'($urandom_range(0, 3)), 8'($urandom()), rnd32(), rnd32(),
             1'($urandom()));
        settle();
      end else begin
        run_list($urandom_range(1, 4), 1'($urandom()));
      end
      send(F_READ, $urandom_range(0, 1) ? OFF_TRIG : OFF_GEN, 0, 0, 0);
      send(F_WRITE, OFF_SYSCTL, $urandom(), 0, 0);
      send(F_WRITE, OFF_MODE, $urandom(), 0, 0);
      send(F_WRITE, OFF_PROT, $urandom_range(0, 1) ? {PROT_KEY, 16'($urandom())} : $urandom(),
           0, 0);
      send(F_WRITE, OFF_GEN, $urandom(), 0, 0);
    end
    settle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== peripheral_bus_dma_controller.f =====
src/pbdma_pkg.sv
src/pbdma_front.sv
src/pbdma_queue.sv
src/pbdma_back.sv
src/peripheral_bus_dma_controller.sv
src/pbdma_checker.sv
tb/tb.sv
